@@ hdl/mexp_pkg.sv @@
// Package for the streaming modular exponentiation block.
// Holds default widths, configuration register indexes and port constants.
// No dependencies.
`default_nettype none

package mexp_pkg;

  localparam int unsigned MOD_BITS_DEF = 32;
  localparam int unsigned EXP_BITS_DEF = 32;
  localparam int unsigned BYTE_BITS    = 8;
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_EXPONENT = CFG_IDX_BITS'(1);

  localparam logic [63:0] MODULUS_RST  = 64'd52008701;
  localparam logic [63:0] EXPONENT_RST = 64'd2;

endpackage

`default_nettype wire

@@ hdl/mexp_step.sv @@
// One pipeline stage of the shift-and-add modular multiplier:
// a doubling or a conditional add of the multiplicand, each mod the modulus.
// Uses mexp_pkg.
`default_nettype none

module mexp_step
  import mexp_pkg::*;
#(
  parameter int unsigned MOD_BITS = MOD_BITS_DEF,
  parameter int unsigned JBIT     = 0,
  parameter bit          SQR      = 1'b1,
  parameter bit          DBL      = 1'b1,
  parameter bit          FIRST    = 1'b0,
  parameter bit          LAST     = 1'b0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                exp_bit_i,
  input  wire logic [MOD_BITS-1:0] modulus_i,
  input  wire logic                valid_i,
  input  wire logic [MOD_BITS-1:0] r_i,
  input  wire logic [MOD_BITS-1:0] base_i,
  input  wire logic [MOD_BITS-1:0] acc_i,
  output logic                     valid_o,
  output logic [MOD_BITS-1:0]      r_o,
  output logic [MOD_BITS-1:0]      base_o,
  output logic [MOD_BITS-1:0]      acc_o
);

  logic                mb;
  logic [MOD_BITS-1:0] x, y, acc_d, r_d;
  logic [MOD_BITS:0]   sum, red;

  always_comb begin
    mb  = SQR ? r_i[JBIT] : base_i[JBIT];
    x   = FIRST ? '0 : acc_i;
    y   = DBL ? x : r_i;
    sum = {1'b0, x} + {1'b0, y};
    red = (sum >= {1'b0, modulus_i}) ? (sum - {1'b0, modulus_i}) : sum;
    acc_d = (DBL || mb) ? red[MOD_BITS-1:0] : x;
    r_d   = (LAST && (SQR || exp_bit_i)) ? acc_d : r_i;
  end

  logic valid_q;
  logic [MOD_BITS-1:0] r_q, base_q, acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q    <= r_d;
      base_q <= base_i;
      acc_q  <= acc_d;
    end
  end

  assign valid_o = valid_q;
  assign r_o     = r_q;
  assign base_o  = base_q;
  assign acc_o   = acc_q;

endmodule

`default_nettype wire

@@ hdl/modular_exponentiation_stream.sv @@
// Top level: streaming modular exponentiation, byte^exponent mod modulus.
// Depends on mexp_pkg and mexp_step.
//
// Usage: one message byte per transaction on the input channel (valid/ready),
// one power_residue per transaction on the output channel, in order.
// modulus (index 0) and exponent (index 1) are written through the plain
// write port (cfg_we_i, cfg_idx_i, cfg_wdata_i) while the block is idle.
// Pipeline: eight restoring-remainder stages reduce the byte, then every
// exponent bit runs a square and a multiply, each one bit of the multiplier
// per two stages (double, then conditional add).
// Throughput: one transaction per cycle. The whole pipeline advances when
// the output register is empty or taken; while the receiver stalls, all
// stages and in_ready_o hold.
// Reset: all stages empty, modulus 52008701, exponent 2.
`default_nettype none

module modular_exponentiation_stream
  import mexp_pkg::*;
#(
  parameter int unsigned MOD_BITS = MOD_BITS_DEF,
  parameter int unsigned EXP_BITS = EXP_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [((MOD_BITS > EXP_BITS) ? MOD_BITS : EXP_BITS)-1:0] cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [BYTE_BITS-1:0]    message_byte_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [MOD_BITS-1:0]          power_residue_o
);

  localparam int unsigned DIV_ST = BYTE_BITS;
  localparam int unsigned NST    = EXP_BITS * 4 * MOD_BITS;

  logic [MOD_BITS-1:0] modulus_q;
  logic [EXP_BITS-1:0] exponent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= MODULUS_RST[MOD_BITS-1:0];
      exponent_q <= EXPONENT_RST[EXP_BITS-1:0];
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MODULUS) begin
        modulus_q <= cfg_wdata_i[MOD_BITS-1:0];
      end
      if (cfg_idx_i == CFG_EXPONENT) begin
        exponent_q <= cfg_wdata_i[EXP_BITS-1:0];
      end
    end
  end

  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // base reduction: byte mod modulus, one quotient bit per stage
  logic                 div_v_q    [DIV_ST];
  logic [MOD_BITS-1:0]  div_rem_q  [DIV_ST];
  logic [BYTE_BITS-1:0] div_byte_q [DIV_ST];

  for (genvar d = 0; d < DIV_ST; d++) begin : g_div
    logic                 v_in;
    logic [MOD_BITS-1:0]  rem_in;
    logic [BYTE_BITS-1:0] byte_in;
    logic [MOD_BITS:0]    t, t_red;
    if (d == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign rem_in  = '0;
      assign byte_in = message_byte_i;
    end else begin : g_next
      assign v_in    = div_v_q[d-1];
      assign rem_in  = div_rem_q[d-1];
      assign byte_in = div_byte_q[d-1];
    end
    always_comb begin
      t     = {rem_in, byte_in[DIV_ST-1-d]};
      t_red = (t >= {1'b0, modulus_q}) ? (t - {1'b0, modulus_q}) : t;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[d] <= 1'b0;
      end else if (adv) begin
        div_v_q[d] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_rem_q[d]  <= t_red[MOD_BITS-1:0];
        div_byte_q[d] <= byte_in;
      end
    end
  end

  logic                st_v [NST+1];
  logic [MOD_BITS-1:0] st_r [NST+1];
  logic [MOD_BITS-1:0] st_b [NST+1];
  logic [MOD_BITS-1:0] st_a [NST+1];

  assign st_v[0] = div_v_q[DIV_ST-1];
  assign st_r[0] = (modulus_q == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
  assign st_b[0] = div_rem_q[DIV_ST-1];
  assign st_a[0] = '0;

  for (genvar e = 0; e < EXP_BITS; e++) begin : g_exp
    for (genvar p = 0; p < 2; p++) begin : g_phase
      for (genvar j = 0; j < MOD_BITS; j++) begin : g_bit
        for (genvar h = 0; h < 2; h++) begin : g_half
          localparam int unsigned K = ((e * 2 + p) * MOD_BITS + j) * 2 + h;
          mexp_step #(
            .MOD_BITS (MOD_BITS),
            .JBIT     (MOD_BITS - 1 - j),
            .SQR      (p == 0),
            .DBL      (h == 0),
            .FIRST    (j == 0 && h == 0),
            .LAST     (j == MOD_BITS - 1 && h == 1)
          ) u_step (
            .clk_i     (clk_i),
            .rst_ni    (rst_ni),
            .en_i      (adv),
            .exp_bit_i (exponent_q[EXP_BITS-1-e]),
            .modulus_i (modulus_q),
            .valid_i   (st_v[K]),
            .r_i       (st_r[K]),
            .base_i    (st_b[K]),
            .acc_i     (st_a[K]),
            .valid_o   (st_v[K+1]),
            .r_o       (st_r[K+1]),
            .base_o    (st_b[K+1]),
            .acc_o     (st_a[K+1])
          );
        end
      end
    end
  end

  assign out_valid_o     = st_v[NST];
  assign power_residue_o = (modulus_q == '0) ? '0 : st_r[NST];

  logic unused_acc;
  assign unused_acc = ^st_a[NST] ^ ^st_b[NST];

  a_ready_follows_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow the output register");

  a_stall_holds_front : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(div_v_q[0]) && $stable(st_v[0]))
    else $error("pipeline front moved during a stall");

  a_result_below_modulus : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && modulus_q != '0 |-> power_residue_o < modulus_q)
    else $error("result not reduced");

  a_unit_modulus_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (modulus_q == MOD_BITS'(1) || modulus_q == '0)
      |-> power_residue_o == '0 || unused_acc != unused_acc)
    else $error("result nonzero for modulus one or zero");

endmodule

`default_nettype wire
